/* hdl/ngcrp_pkg.sv */
// Shared constants and register indexes for the grid column ray pick core.
`default_nettype none

package ngcrp_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

    localparam int CFG_DATA_W = 32;
    localparam int COORD_W    = 32;
    localparam int DIR_W      = 16;
    localparam int DIFF_W     = 34;
    localparam int DIV_NUM_W  = 47;
    localparam int QUO_W      = 31;
    localparam int DIST_W     = 64;

    // Register reset values.
    localparam logic signed [COORD_W-1:0] ORIGIN_X_RST = 32'sd0;
    localparam logic signed [COORD_W-1:0] ORIGIN_Y_RST = 32'sd0;
    localparam logic signed [COORD_W-1:0] ORIGIN_Z_RST = 32'sd655360;
    localparam logic signed [DIR_W-1:0]   DIR_X_RST    = 16'sd0;
    localparam logic signed [DIR_W-1:0]   DIR_Y_RST    = 16'sd16384;
    localparam logic signed [DIR_W-1:0]   DIR_Z_RST    = 16'sd0;

    // Ray parameter range and the acceptance window of +-1000.0 in Q16.16.
    localparam logic signed [COORD_W-1:0] T_MAX_SAT = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] T_MIN_SAT = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] T_LIMIT   = 32'sd65536000;
    localparam logic signed [COORD_W-1:0] T_LIMIT_N = -32'sd65536000;

    localparam logic signed [DIFF_W-1:0] CELL_SIZE = 34'sd65536;

endpackage

`default_nettype wire

/* hdl/nearest_grid_column_ray_pick_core.sv */
// Top level of the grid column ray pick core: slab test, divider and nearest-hit search.
//
// Usage: program the ray with cfg_wr_en / cfg_index / cfg_wr_data while the core is
// idle (origin x, y, z in Q16.16 at indexes 0..2, direction x, y, z in Q2.14 at 3..5).
// Then stream grid columns on the s_ channel (s_col, s_row, s_height, s_last) with
// valid/ready. Each column is tested against the ray; the nearest hit is kept. The
// column marked s_last produces one item on the m_ channel (m_found, m_best_col,
// m_best_row) and clears the search so the next scan starts fresh.
// Sequence: when all three direction components are nonzero, a column runs per axis
// two restoring divisions of 31 steps each through the one shared divider plus setup,
// store and clip states, then the squared distance through a single 32x32 multiplier
// and the compare. A quotient that saturates skips its 31 divider steps, an axis with
// a zero direction is settled without the divider, and a column rejected early skips
// the remaining axes and the distance. s_ready is high only between columns.
// The result sits in an output register; the core takes the next column while it
// waits, and holds only when a new result is due before the old one was taken.
// Reset (synchronous, active low) restores the register defaults, clears the search
// and drops m_valid.
`default_nettype none

module nearest_grid_column_ray_pick_core
    import ngcrp_pkg::*;
#(
    parameter int GRID_SIDE = 256
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire [7:0]            s_col,
    input  wire [7:0]            s_row,
    input  wire [15:0]           s_height,
    input  wire                  s_last,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic                 m_found,
    output logic [7:0]           m_best_col,
    output logic [7:0]           m_best_row
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_AXIS  = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_STORE = 4'd3;
    localparam logic [3:0] ST_CLIP  = 4'd4;
    localparam logic [3:0] ST_CHECK = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_ACC   = 4'd7;
    localparam logic [3:0] ST_CMP   = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;

    localparam logic [4:0] DIV_LAST = 5'(QUO_W - 1);

    // Configuration registers.
    logic signed [COORD_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [DIR_W-1:0]   dir_x_reg, dir_y_reg, dir_z_reg;

    // Sequencer and datapath registers.
    logic [3:0]                state_reg, state_next;
    logic [7:0]                col_reg, col_next;
    logic [7:0]                row_reg, row_next;
    logic [15:0]               height_reg, height_next;
    logic                      last_reg, last_next;
    logic                      hit_reg, hit_next;
    logic [1:0]                axis_reg, axis_next;
    logic                      side_reg, side_next;
    logic [4:0]                cnt_reg, cnt_next;
    logic [15:0]               rem_reg, rem_next;
    logic [QUO_W-1:0]          quo_reg, quo_next;
    logic [DIR_W-1:0]          dm_reg, dm_next;
    logic                      neg_reg, neg_next;
    logic                      sat_reg, sat_next;
    logic signed [COORD_W-1:0] ta_reg, ta_next;
    logic signed [COORD_W-1:0] tb_reg, tb_next;
    logic signed [COORD_W-1:0] enter_reg, enter_next;
    logic signed [COORD_W-1:0] exit_reg, exit_next;
    logic [DIST_W-1:0]         prod_reg, prod_next;
    logic [DIST_W-1:0]         dist_reg, dist_next;
    logic [DIST_W-1:0]         best_dist_reg, best_dist_next;
    logic [7:0]                best_col_reg, best_col_next;
    logic [7:0]                best_row_reg, best_row_next;
    logic                      any_hit_reg, any_hit_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      m_found_reg, m_found_next;
    logic [7:0]                m_col_reg, m_col_next;
    logic [7:0]                m_row_reg, m_row_next;

    // Per-axis selection of bounds, origin and direction.
    logic signed [DIFF_W-1:0] sel_lo, sel_hi, sel_o;
    logic signed [DIR_W-1:0]  sel_d;
    logic signed [DIFF_W-1:0] slab_diff;
    logic [DIFF_W-2:0]        slab_mag;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIR_W-1:0]         dir_mag;
    logic                     div_sat;
    logic [16:0]              div_shift;
    logic                     div_ge;
    logic signed [COORD_W-1:0] quo_signed;
    logic signed [COORD_W-1:0] t_lo, t_hi;
    logic signed [DIFF_W-1:0] dist_diff;
    logic [COORD_W-1:0]       dist_mag;
    logic [DIST_W:0]          dist_sum;
    logic                     in_grid;
    logic                     window_ok;

    always_comb begin
        unique case (axis_reg)
            2'd0: begin
                sel_lo = $signed({10'b0, col_reg, 16'b0});
                sel_hi = sel_lo + CELL_SIZE;
                sel_o  = DIFF_W'(origin_x_reg);
                sel_d  = dir_x_reg;
            end
            2'd1: begin
                sel_lo = $signed({10'b0, row_reg, 16'b0});
                sel_hi = sel_lo + CELL_SIZE;
                sel_o  = DIFF_W'(origin_y_reg);
                sel_d  = dir_y_reg;
            end
            2'd2: begin
                sel_lo = '0;
                sel_hi = $signed({10'b0, height_reg, 8'b0});
                sel_o  = DIFF_W'(origin_z_reg);
                sel_d  = dir_z_reg;
            end
            default: begin
                sel_lo = '0;
                sel_hi = '0;
                sel_o  = '0;
                sel_d  = '0;
            end
        endcase
    end

    // Numerator magnitude is |bound - origin| * 2^14; the quotient saturates when it
    // would reach 2^31, so the divider only ever produces 31 bits.
    assign slab_diff = (side_reg ? sel_hi : sel_lo) - sel_o;
    assign slab_mag  = slab_diff[DIFF_W-1] ? (DIFF_W-1)'(-slab_diff)
                                           : slab_diff[DIFF_W-2:0];
    assign div_num   = {slab_mag, 14'b0};
    assign dir_mag   = sel_d[DIR_W-1] ? DIR_W'(-sel_d) : sel_d;
    assign div_sat   = div_num >= {dir_mag, 31'b0};

    assign div_shift = {rem_reg, quo_reg[QUO_W-1]};
    assign div_ge    = div_shift >= {1'b0, dm_reg};

    assign quo_signed = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    assign t_lo = (ta_reg > tb_reg) ? tb_reg : ta_reg;
    assign t_hi = (ta_reg > tb_reg) ? ta_reg : tb_reg;

    // Squared distance terms: x0 - ox, y0 - oy, top - oz, all below 2^32 in magnitude.
    assign dist_diff = ((axis_reg == 2'd2) ? sel_hi : sel_lo) - sel_o;
    assign dist_mag  = dist_diff[DIFF_W-1] ? COORD_W'(-dist_diff) : dist_diff[COORD_W-1:0];
    assign dist_sum  = {1'b0, dist_reg} + {1'b0, prod_reg};

    assign in_grid   = ({24'b0, s_col} < 32'(GRID_SIDE)) && ({24'b0, s_row} < 32'(GRID_SIDE));
    assign window_ok = (enter_reg <= exit_reg) && (enter_reg <= T_LIMIT)
                       && (exit_reg >= T_LIMIT_N);

    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        height_next    = height_reg;
        last_next      = last_reg;
        hit_next       = hit_reg;
        axis_next      = axis_reg;
        side_next      = side_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dm_next        = dm_reg;
        neg_next       = neg_reg;
        sat_next       = sat_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        enter_next     = enter_reg;
        exit_next      = exit_reg;
        prod_next      = prod_reg;
        dist_next      = dist_reg;
        best_dist_next = best_dist_reg;
        best_col_next  = best_col_reg;
        best_row_next  = best_row_reg;
        any_hit_next   = any_hit_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_found_next   = m_found_reg;
        m_col_next     = m_col_reg;
        m_row_next     = m_row_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    col_next    = s_col;
                    row_next    = s_row;
                    height_next = s_height;
                    last_next   = s_last;
                    hit_next    = in_grid;
                    axis_next   = 2'd0;
                    side_next   = 1'b0;
                    enter_next  = T_MIN_SAT;
                    exit_next   = T_MAX_SAT;
                    state_next  = ST_AXIS;
                end
            end
            ST_AXIS: begin
                if (!hit_reg || axis_reg == 2'd3) begin
                    state_next = ST_CHECK;
                end else if (sel_d == '0) begin
                    // The slab places no bound on t; it only decides hit or miss.
                    hit_next  = (sel_o >= sel_lo) && (sel_o <= sel_hi);
                    axis_next = axis_reg + 2'd1;
                end else begin
                    neg_next   = slab_diff[DIFF_W-1] ^ sel_d[DIR_W-1];
                    dm_next    = dir_mag;
                    sat_next   = div_sat;
                    rem_next   = div_num[DIV_NUM_W-1:QUO_W];
                    quo_next   = div_num[QUO_W-1:0];
                    cnt_next   = '0;
                    state_next = div_sat ? ST_STORE : ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = div_ge ? 16'(div_shift - {1'b0, dm_reg}) : div_shift[15:0];
                quo_next = {quo_reg[QUO_W-2:0], div_ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                if (!side_reg) begin
                    ta_next    = sat_reg ? (neg_reg ? T_MIN_SAT : T_MAX_SAT) : quo_signed;
                    side_next  = 1'b1;
                    state_next = ST_AXIS;
                end else begin
                    tb_next    = sat_reg ? (neg_reg ? T_MIN_SAT : T_MAX_SAT) : quo_signed;
                    side_next  = 1'b0;
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP: begin
                if (t_lo > enter_reg) begin
                    enter_next = t_lo;
                end
                if (t_hi < exit_reg) begin
                    exit_next = t_hi;
                end
                axis_next  = axis_reg + 2'd1;
                state_next = ST_AXIS;
            end
            ST_CHECK: begin
                if (hit_reg && window_ok) begin
                    axis_next  = 2'd0;
                    dist_next  = '0;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_MUL: begin
                prod_next  = {32'b0, dist_mag} * {32'b0, dist_mag};
                state_next = ST_ACC;
            end
            ST_ACC: begin
                dist_next = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
                if (axis_reg == 2'd2) begin
                    state_next = ST_CMP;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_CMP: begin
                // Strict less keeps the earliest column on equal distance.
                if (dist_reg < best_dist_reg) begin
                    best_dist_next = dist_reg;
                    best_col_next  = col_reg;
                    best_row_next  = row_reg;
                    any_hit_next   = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_found_next   = any_hit_reg;
                    m_col_next     = best_col_reg;
                    m_row_next     = best_row_reg;
                    best_dist_next = '1;
                    best_col_next  = '0;
                    best_row_next  = '0;
                    any_hit_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            best_dist_reg <= '1;
            best_col_reg  <= '0;
            best_row_reg  <= '0;
            any_hit_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_found_reg   <= 1'b0;
            m_col_reg     <= '0;
            m_row_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            best_dist_reg <= best_dist_next;
            best_col_reg  <= best_col_next;
            best_row_reg  <= best_row_next;
            any_hit_reg   <= any_hit_next;
            m_valid_reg   <= m_valid_next;
            m_found_reg   <= m_found_next;
            m_col_reg     <= m_col_next;
            m_row_reg     <= m_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg    <= col_next;
        row_reg    <= row_next;
        height_reg <= height_next;
        last_reg   <= last_next;
        hit_reg    <= hit_next;
        axis_reg   <= axis_next;
        side_reg   <= side_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dm_reg     <= dm_next;
        neg_reg    <= neg_next;
        sat_reg    <= sat_next;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        enter_reg  <= enter_next;
        exit_reg   <= exit_next;
        prod_reg   <= prod_next;
        dist_reg   <= dist_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= ORIGIN_X_RST;
            origin_y_reg <= ORIGIN_Y_RST;
            origin_z_reg <= ORIGIN_Z_RST;
            dir_x_reg    <= DIR_X_RST;
            dir_y_reg    <= DIR_Y_RST;
            dir_z_reg    <= DIR_Z_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ORIGIN_X: origin_x_reg <= cfg_wr_data;
                REG_ORIGIN_Y: origin_y_reg <= cfg_wr_data;
                REG_ORIGIN_Z: origin_z_reg <= cfg_wr_data;
                REG_DIR_X:    dir_x_reg    <= cfg_wr_data[DIR_W-1:0];
                REG_DIR_Y:    dir_y_reg    <= cfg_wr_data[DIR_W-1:0];
                REG_DIR_Z:    dir_z_reg    <= cfg_wr_data[DIR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_best_col = m_col_reg;
    assign m_best_row = m_row_reg;

    // An empty search must still carry the no-hit distance.
    a_empty_search : assert property (@(posedge aclk) disable iff (!aresetn)
        !any_hit_reg |-> (&best_dist_reg))
        else $error("search state without a hit lost its reset distance");

    // A result without a hit reports column and row zero.
    a_no_hit_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_best_col == 8'd0 && m_best_row == 8'd0))
        else $error("no-hit result carries a nonzero position");

    // Accepting a column starts the sequencer, so ready drops.
    a_busy_after_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("core still ready after taking a column");

    // The divider never runs past its last quotient bit.
    a_div_count : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg <= DIV_LAST))
        else $error("divider step count overran");

endmodule

`default_nettype wire

/* verif/tb_nearest_grid_column_ray_pick_core.sv */
// Self-checking testbench for the grid column ray pick core.
`timescale 1ns / 100ps

module tb_nearest_grid_column_ray_pick_core;
    import ngcrp_pkg::*;

    localparam int RANDOM_ITEMS   = 1880;
    localparam int SETTLE_CYCLES  = 400;
    localparam int HOLD_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [7:0]  col;
        logic [7:0]  row;
        logic [15:0] height;
        logic        last;
    } column_t;

    typedef struct packed {
        logic       found;
        logic [7:0] col;
        logic [7:0] row;
    } pick_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_col = '0;
    logic [7:0] s_row = '0;
    logic [15:0] s_height = '0;
    logic s_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_found;
    logic [7:0] m_best_col;
    logic [7:0] m_best_row;

    // Ray registers as the core should hold them, and the running search.
    longint ray_org [3] = '{0, 0, 655360};
    longint ray_dir [3] = '{0, 16384, 0};
    longint unsigned best_dist = '1;
    logic [7:0] best_c = '0;
    logic [7:0] best_r = '0;
    logic any_hit = 1'b0;

    column_t columns_todo [$];
    pick_t picks_due [$];
    column_t next_col;
    pick_t want;
    logic column_busy = 1'b0;
    logic idle_on = 1'b1;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int quiet_cycles = 0;
    int errors = 0;

    nearest_grid_column_ray_pick_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_col       (s_col),
        .s_row       (s_row),
        .s_height    (s_height),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_found     (m_found),
        .m_best_col  (m_best_col),
        .m_best_row  (m_best_row)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int draw_gap();
        int pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint clamp_t(input longint q);
        if (q > longint'(T_MAX_SAT)) return longint'(T_MAX_SAT);
        if (q < longint'(T_MIN_SAT)) return longint'(T_MIN_SAT);
        return q;
    endfunction

    // Narrows the parameter window by one slab; a zero direction only checks the origin.
    function automatic bit narrow_slab(input longint lo_b, input longint hi_b,
                                       input longint org, input longint dir,
                                       inout longint t_in, inout longint t_out);
        longint a;
        longint b;
        longint tmp;
        if (dir == 0) return (org >= lo_b) && (org <= hi_b);
        a = clamp_t(((lo_b - org) * 16384) / dir);
        b = clamp_t(((hi_b - org) * 16384) / dir);
        if (a > b) begin
            tmp = a;
            a = b;
            b = tmp;
        end
        if (a > t_in) t_in = a;
        if (b < t_out) t_out = b;
        return 1'b1;
    endfunction

    function automatic longint unsigned sq_mag(input longint v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    function automatic longint unsigned add_sat(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    // Tests one column against the ray and, on the last column, queues the pick.
    function automatic void take_column(input logic [7:0] c, input logic [7:0] r,
                                        input logic [15:0] h, input logic lst);
        longint x0;
        longint y0;
        longint z_top;
        longint t_in;
        longint t_out;
        longint unsigned sq_sum;
        bit hit;
        pick_t res;
        x0 = longint'(c) << 16;
        y0 = longint'(r) << 16;
        z_top = longint'(h) << 8;
        t_in = longint'(T_MIN_SAT);
        t_out = longint'(T_MAX_SAT);
        hit = narrow_slab(x0, x0 + 65536, ray_org[0], ray_dir[0], t_in, t_out);
        if (hit) hit = narrow_slab(y0, y0 + 65536, ray_org[1], ray_dir[1], t_in, t_out);
        if (hit) hit = narrow_slab(0, z_top, ray_org[2], ray_dir[2], t_in, t_out);
        if (hit) begin
            hit = (t_in <= t_out) && (t_in <= longint'(T_LIMIT))
                && (t_out >= longint'(T_LIMIT_N));
        end
        if (hit) begin
            sq_sum = add_sat(sq_mag(x0 - ray_org[0]), sq_mag(y0 - ray_org[1]));
            sq_sum = add_sat(sq_sum, sq_mag(z_top - ray_org[2]));
            if (sq_sum < best_dist) begin
                best_dist = sq_sum;
                best_c = c;
                best_r = r;
                any_hit = 1'b1;
            end
        end
        if (lst) begin
            res.found = any_hit;
            res.col = any_hit ? best_c : 8'd0;
            res.row = any_hit ? best_r : 8'd0;
            picks_due.push_back(res);
            best_dist = '1;
            best_c = '0;
            best_r = '0;
            any_hit = 1'b0;
        end
    endfunction

    function automatic logic [31:0] corner_value(input int w);
        logic [31:0] top = 32'h1 << (w - 1);
        case ($urandom_range(0, 5))
            0: return top;
            1: return top - 1;
            2: return '0;
            3: return '1;
            4: return 32'd1;
            default: return $urandom();
        endcase
    endfunction

    // Driver: feeds queued columns and predicts each one as it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                take_column(s_col, s_row, s_height, s_last);
                column_busy = 1'b0;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (columns_todo.size() != 0) begin
                    next_col = columns_todo.pop_front();
                    column_busy = 1'b1;
                    s_col <= next_col.col;
                    s_row <= next_col.row;
                    s_height <= next_col.height;
                    s_last <= next_col.last;
                    s_valid <= 1'b1;
                    send_gap = idle_on ? draw_gap() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each pick and throttles m_ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (picks_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected pick: expected none, got found %0b col %0d row %0d",
                             $time, m_found, m_best_col, m_best_row);
                end else begin
                    want = picks_due.pop_front();
                    if (m_found !== want.found) begin
                        errors++;
                        $display("%0t: found mismatch: expected %0b, got %0b",
                                 $time, want.found, m_found);
                    end
                    if (m_best_col !== want.col) begin
                        errors++;
                        $display("%0t: best_col mismatch: expected %0d, got %0d",
                                 $time, want.col, m_best_col);
                    end
                    if (m_best_row !== want.row) begin
                        errors++;
                        $display("%0t: best_row mismatch: expected %0d, got %0d",
                                 $time, want.row, m_best_row);
                    end
                end
            end
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = draw_gap();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ORIGIN_X: ray_org[0] = longint'($signed(data));
            REG_ORIGIN_Y: ray_org[1] = longint'($signed(data));
            REG_ORIGIN_Z: ray_org[2] = longint'($signed(data));
            REG_DIR_X:    ray_dir[0] = longint'($signed(data[15:0]));
            REG_DIR_Y:    ray_dir[1] = longint'($signed(data[15:0]));
            REG_DIR_Z:    ray_dir[2] = longint'($signed(data[15:0]));
            default: ;
        endcase
    endtask

    task automatic program_ray(input logic [31:0] ox, input logic [31:0] oy,
                               input logic [31:0] oz, input logic [15:0] dx,
                               input logic [15:0] dy, input logic [15:0] dz);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIR_X, {{16{dx[15]}}, dx});
        write_reg(REG_DIR_Y, {{16{dy[15]}}, dy});
        write_reg(REG_DIR_Z, {{16{dz[15]}}, dz});
    endtask

    task automatic queue_column(input logic [7:0] c, input logic [7:0] r,
                                input logic [15:0] h, input logic lst);
        column_t item;
        item.col = c;
        item.row = r;
        item.height = h;
        item.last = lst;
        columns_todo.push_back(item);
    endtask

    // Waits until the scan is fully answered, then lets the core settle.
    task automatic wait_scan_done();
        while (columns_todo.size() != 0 || column_busy || picks_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
        column_t item;
        int kind;
        int scan_len;
        int phase_no;
        int queued;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Ray after reset: from (0,0,10) along +y. Nearer hit, miss, tie, no hit.
        queue_column(8'd0, 8'd5, 16'd2560, 1'b0);
        queue_column(8'd0, 8'd3, 16'd3000, 1'b0);
        queue_column(8'd1, 8'd3, 16'd9000, 1'b0);
        queue_column(8'd0, 8'd3, 16'd3000, 1'b1);
        queue_column(8'd0, 8'd0, 16'd0, 1'b1);
        queue_column(8'd0, 8'd255, 16'hFFFF, 1'b1);
        queue_column(8'd255, 8'd255, 16'hFFFF, 1'b1);
        wait_scan_done();

        // Diagonal ray: the column at (1,0) is entered and left at the same t.
        program_ray(32'd0, 32'd0, 32'd655360, 16'd16384, 16'd16384, 16'd0);
        queue_column(8'd1, 8'd0, 16'd2560, 1'b0);
        queue_column(8'd2, 8'd2, 16'd2560, 1'b1);
        wait_scan_done();

        // Extreme origin and direction values; the tiny x direction saturates the x parameters.
        program_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 16'h0001, 16'h8000, 16'h7FFF);
        queue_column(8'd0, 8'd0, 16'd0, 1'b0);
        queue_column(8'd255, 8'd255, 16'hFFFF, 1'b0);
        queue_column(8'd128, 8'd64, 16'd1, 1'b1);
        wait_scan_done();

        // Straight down with x and y on cell borders, which count as inside.
        program_ray(32'd5 << 16, 32'd7 << 16, 32'd20 << 16, 16'd0, 16'd0, 16'hC000);
        queue_column(8'd4, 8'd7, 16'd256, 1'b0);
        queue_column(8'd5, 8'd6, 16'd256, 1'b0);
        queue_column(8'd5, 8'd7, 16'd512, 1'b1);
        wait_scan_done();

        // A tiny direction pushes the entry beyond +1000 for every row but the first.
        program_ray(32'h8000, 32'h8000, 32'h8000, 16'd0, 16'h0001, 16'd0);
        queue_column(8'd0, 8'd0, 16'd128, 1'b0);
        queue_column(8'd0, 8'd1, 16'd128, 1'b0);
        queue_column(8'd0, 8'd2, 16'hFFFF, 1'b1);
        wait_scan_done();

        // Reversed, so the exit falls below -1000 for the rows ahead.
        program_ray(32'h8000, 32'h8000, 32'h8000, 16'd0, 16'hFFFF, 16'd0);
        queue_column(8'd0, 8'd1, 16'd128, 1'b0);
        queue_column(8'd0, 8'd0, 16'd128, 1'b1);
        wait_scan_done();

        queued = 0;
        phase_no = 0;
        while (queued < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                ox = $urandom_range(0, 32'h00FF_FFFF);
                oy = $urandom_range(0, 32'h00FF_FFFF);
                oz = $urandom_range(0, 200 * 65536);
                dx = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom());
                dy = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom());
                dz = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom());
            end else if (kind <= 6) begin
                ox = corner_value(32);
                oy = corner_value(32);
                oz = corner_value(32);
                dx = 16'(corner_value(16));
                dy = 16'(corner_value(16));
                dz = 16'(corner_value(16));
            end else if (kind == 7) begin
                ox = $urandom();
                oy = $urandom();
                oz = $urandom();
                dx = 16'($urandom());
                dy = 16'($urandom());
                dz = 16'($urandom());
            end else begin
                // Axis-aligned ray from inside the grid.
                ox = $urandom_range(0, 32'h00FF_FFFF);
                oy = $urandom_range(0, 32'h00FF_FFFF);
                oz = $urandom_range(0, 200 * 65536);
                dx = 16'd0;
                dy = 16'd0;
                dz = 16'd0;
                case ($urandom_range(0, 2))
                    0: dx = ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000;
                    1: dy = ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000;
                    default: dz = 16'($urandom());
                endcase
            end
            program_ray(ox, oy, oz, dx, dy, dz);

            if (phase_no == 3) begin
                // Every column ends a scan while the receiver holds off, so the core stalls behind its unread result.
                idle_on = 1'b0;
                hold_requests++;
                scan_len = 16;
            end else begin
                scan_len = $urandom_range(1, 30);
            end
            for (int i = 0; i < scan_len; i++) begin
                if (kind <= 4 || kind >= 8) begin
                    item.col = 8'(ox[23:16] + $urandom_range(0, 8) - 4);
                    item.row = 8'(oy[23:16] + $urandom_range(0, 8) - 4);
                end else begin
                    item.col = 8'($urandom());
                    item.row = 8'($urandom());
                end
                item.height = ($urandom_range(0, 1) != 0) ? 16'($urandom())
                                                          : 16'($urandom_range(0, 16'h4000));
                item.last = (i == scan_len - 1) || (phase_no == 3)
                    || ($urandom_range(0, 11) == 0);
                columns_todo.push_back(item);
            end
            queued += scan_len;
            wait_scan_done();
            phase_no++;
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
